### rtl/core/ordered_id_list_delete_before_macros.svh
// assertion helpers shared by the checker
`ifndef ORDERED_ID_LIST_DELETE_BEFORE_MACROS_SVH
`define ORDERED_ID_LIST_DELETE_BEFORE_MACROS_SVH

// generic clocked check on clk, idle while arst_n is low
`define OIDL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled word keeps its payload
`define OIDL_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
	`OIDL_ASSERT(lbl, ((vld) && (stl)) |=> $stable(sig), msg)

`endif

### rtl/core/oidl_pkg.sv
package oidl_pkg;

	localparam int ID_W     = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	// wide enough for any cell index or count up to 127
	localparam int POS_W    = 7;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_APPENDED  = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_REF_FIRST = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_ENTRY     = 3'd5;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_CLOSE,
		OP_APPEND
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] tail;
		logic [POS_W-1:0] sel;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH,
		S_DUMP
	} state_t;

endpackage

### rtl/core/oidl_cell.sv
module oidl_cell #(
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  oidl_pkg::cell_ctrl_t      ctrl,
	input  logic [oidl_pkg::ID_W-1:0] next_id,
	input  logic [oidl_pkg::ID_W-1:0] head_id,
	input  logic [oidl_pkg::ID_W-1:0] new_id,
	output logic [oidl_pkg::ID_W-1:0] id
);

	localparam logic [oidl_pkg::POS_W-1:0] IDX = oidl_pkg::POS_W'(INDEX);

	logic [oidl_pkg::ID_W-1:0] id_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			oidl_pkg::OP_ROTATE: begin
				// head word wraps around to the tail
				if (IDX == ctrl.tail) begin
					id_q <= head_id;
				end else if (IDX < ctrl.tail) begin
					id_q <= next_id;
				end
			end
			oidl_pkg::OP_CLOSE: begin
				if (IDX >= ctrl.sel && IDX < ctrl.tail) begin
					id_q <= next_id;
				end
			end
			oidl_pkg::OP_APPEND: begin
				if (IDX == ctrl.sel) begin
					id_q <= new_id;
				end
			end
			default: begin
			end
		endcase
	end

	assign id = id_q;

endmodule

### rtl/core/ordered_id_list_delete_before.sv
// ordered id list, one id per cell, head in cell zero
// append: result in the cycle after the word is taken; the next word waits while it is stalled
// delete-before: one rotation through the cells, then the result from the finish state
// dump: the word enters the dump state, which gives one id per cycle while not stalled
// one item in flight at a time; the walk over the cell chain sets the rate; stalls hold it
// arst_n clears the count, the controller and the result valid flag; ids are undefined
module ordered_id_list_delete_before #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [oidl_pkg::KIND_W-1:0]          kind,
	input  logic signed [oidl_pkg::ID_W-1:0]     entry_id,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [oidl_pkg::STATUS_W-1:0]        status,
	output logic signed [oidl_pkg::ID_W-1:0]     result_id,
	output logic                                 last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	oidl_pkg::state_t     state_q, state_d;
	oidl_pkg::cell_ctrl_t ctrl;

	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          walk_q;
	logic [IDX_W-1:0]          pos_q;
	logic                      found_q;
	logic [oidl_pkg::ID_W-1:0] ref_q;
	logic [oidl_pkg::ID_W-1:0] prev_q;
	logic [oidl_pkg::ID_W-1:0] removed_q;

	logic                          rsp_valid_q;
	logic [oidl_pkg::STATUS_W-1:0] status_q;
	logic [oidl_pkg::ID_W-1:0]     result_id_q;
	logic                          last_q;

	logic [oidl_pkg::ID_W-1:0] cell_id [CAPACITY];
	logic [oidl_pkg::ID_W-1:0] head_id;
	logic [CNT_W-1:0]          tail_cnt;
	logic                      walk_last;
	logic                      out_free;

	logic                          out_load;
	logic [oidl_pkg::STATUS_W-1:0] out_status;
	logic [oidl_pkg::ID_W-1:0]     out_id;
	logic                          out_last;
	logic                          count_inc;
	logic                          count_dec;
	logic                          walk_clr;
	logic                          walk_inc;
	logic                          search_step;

	assign head_id   = cell_id[0];
	assign tail_cnt  = count_q - CNT_W'(1);
	assign walk_last = (CNT_W'(walk_q) == tail_cnt);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == oidl_pkg::S_IDLE) && out_free);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [oidl_pkg::ID_W-1:0] nbr_id;
		if (i < CAPACITY - 1) begin : g_mid
			assign nbr_id = cell_id[i+1];
		end else begin : g_end
			assign nbr_id = '0;
		end
		oidl_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.next_id(nbr_id),
			.head_id(head_id),
			.new_id (entry_id),
			.id     (cell_id[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oidl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.op     = oidl_pkg::OP_HOLD;
		ctrl.tail   = oidl_pkg::POS_W'(tail_cnt);
		ctrl.sel    = '0;
		out_load    = 1'b0;
		out_status  = oidl_pkg::STATUS_APPENDED;
		out_id      = '0;
		out_last    = 1'b1;
		count_inc   = 1'b0;
		count_dec   = 1'b0;
		walk_clr    = 1'b0;
		walk_inc    = 1'b0;
		search_step = 1'b0;
		unique case (state_q)
			oidl_pkg::S_IDLE: begin
				if (req_valid && out_free) begin
					case (kind)
						oidl_pkg::KIND_APPEND: begin
							out_load = 1'b1;
							if (count_q == CNT_W'(CAPACITY)) begin
								out_status = oidl_pkg::STATUS_FULL;
							end else begin
								ctrl.op   = oidl_pkg::OP_APPEND;
								ctrl.sel  = oidl_pkg::POS_W'(count_q);
								count_inc = 1'b1;
							end
						end
						oidl_pkg::KIND_DELETE: begin
							if (count_q == '0) begin
								out_load   = 1'b1;
								out_status = oidl_pkg::STATUS_EMPTY;
							end else begin
								walk_clr = 1'b1;
								state_d  = oidl_pkg::S_SEARCH;
							end
						end
						oidl_pkg::KIND_DUMP: begin
							if (count_q == '0) begin
								out_load   = 1'b1;
								out_status = oidl_pkg::STATUS_EMPTY;
							end else begin
								walk_clr = 1'b1;
								state_d  = oidl_pkg::S_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			oidl_pkg::S_SEARCH: begin
				// full rotation brings the list back to its original order
				ctrl.op     = oidl_pkg::OP_ROTATE;
				search_step = 1'b1;
				walk_inc    = 1'b1;
				if (walk_last) begin
					state_d = oidl_pkg::S_FINISH;
				end
			end
			oidl_pkg::S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = oidl_pkg::S_IDLE;
					if (!found_q) begin
						out_status = oidl_pkg::STATUS_NOT_FOUND;
					end else if (pos_q == '0) begin
						out_status = oidl_pkg::STATUS_REF_FIRST;
					end else begin
						out_status = oidl_pkg::STATUS_ENTRY;
						out_id     = removed_q;
						ctrl.op    = oidl_pkg::OP_CLOSE;
						ctrl.sel   = oidl_pkg::POS_W'(pos_q - IDX_W'(1));
						count_dec  = 1'b1;
					end
				end
			end
			oidl_pkg::S_DUMP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = oidl_pkg::STATUS_ENTRY;
					out_id     = head_id;
					out_last   = walk_last;
					ctrl.op    = oidl_pkg::OP_ROTATE;
					walk_inc   = 1'b1;
					if (walk_last) begin
						state_d = oidl_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = oidl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (walk_clr) begin
				found_q <= 1'b0;
			end else if (search_step && !found_q && head_id == ref_q) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_clr) begin
			walk_q <= '0;
			ref_q  <= entry_id;
		end else if (walk_inc) begin
			walk_q <= walk_q + IDX_W'(1);
		end
		if (search_step) begin
			prev_q <= head_id;
			// first match from the head; the word before it is the one to drop
			if (!found_q && head_id == ref_q) begin
				pos_q     <= walk_q;
				removed_q <= prev_q;
			end
		end
		if (out_load) begin
			status_q    <= out_status;
			result_id_q <= out_id;
			last_q      <= out_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign result_id = result_id_q;
	assign last      = last_q;

endmodule

### rtl/core/oidl_checker.sv
`include "ordered_id_list_delete_before_macros.svh"

module oidl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_stall,
	input logic [oidl_pkg::KIND_W-1:0]      kind,
	input logic signed [oidl_pkg::ID_W-1:0] entry_id,
	input logic                             rsp_valid,
	input logic                             rsp_stall,
	input logic [oidl_pkg::STATUS_W-1:0]    status,
	input logic signed [oidl_pkg::ID_W-1:0] result_id,
	input logic                             last
);

	logic append_taken;

	assign append_taken = req_valid && !req_stall && (kind == oidl_pkg::KIND_APPEND);

	`OIDL_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_stall, {status, result_id, last}, "rsp word changed under stall")

	// every status but a removed or dumped id ends the item and carries no id
	`OIDL_ASSERT(a_plain_status, (rsp_valid && status != oidl_pkg::STATUS_ENTRY) |-> (last && result_id == '0), "plain status without last or with id")

	// an append answers in the very next cycle
	`OIDL_ASSERT(a_append_resp, append_taken |=> (rsp_valid && last && (status == oidl_pkg::STATUS_APPENDED || status == oidl_pkg::STATUS_FULL)), "append not answered next cycle")

	// no new word is taken while a result still waits under stall
	`OIDL_ASSERT(a_no_take_blocked, (rsp_valid && rsp_stall) |-> req_stall, "word taken while result blocked")

endmodule

bind ordered_id_list_delete_before oidl_checker u_oidl_checker (.*);
